>>> rtl/opts_pkg.sv
// Package for the order priority tick scheduler: payload structs, the task
// table entry layout and the operation codes. No dependencies.
`timescale 1ns / 1ps

package opts_pkg;

    localparam int CFG_W   = 5;
    localparam int SLOT_W  = 4;
    localparam int FIELD_W = 16;
    localparam int ORDER_W = 7;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic               op;
        logic [SLOT_W-1:0]  slot;
        logic [FIELD_W-1:0] arrival;
        logic [FIELD_W-1:0] burst;
        logic [ORDER_W-1:0] order;
    } opts_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] time_now;
        logic               idle;
        logic [SLOT_W-1:0]  chosen;
        logic               finished;
        logic [FIELD_W-1:0] response;
        logic [FIELD_W-1:0] waiting;
        logic [FIELD_W-1:0] turnaround;
        logic               all_done;
    } opts_out_t;

    // Fixed-width part of one task table word; the first-run time is kept
    // next to it at the scheduler's time width.
    typedef struct packed {
        logic [FIELD_W-1:0] arrival;
        logic [FIELD_W-1:0] burst;
        logic [ORDER_W-1:0] order;
        logic [FIELD_W-1:0] remaining;
    } opts_entry_t;

endpackage

>>> rtl/opts_task_ram.sv
// Task table memory: one write port and one read port with registered data.
// No package dependencies.
`timescale 1ns / 1ps

module opts_task_ram #(
    parameter int DATA_W = 87,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/opts_sched_core.sv
// Scheduler sequencer: scans the task table one entry per cycle, updates the
// chosen entry and builds the result. Uses opts_pkg and opts_task_ram.
`timescale 1ns / 1ps

module opts_sched_core
    import opts_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CFG_W-1:0] num_tasks,
    input  logic             in_valid,
    output logic             in_ready,
    input  opts_in_t         in_data,
    output logic             res_valid,
    input  logic             res_ready,
    output opts_out_t        res_data
);

    localparam int IDX_W   = $clog2(MAX_TASKS);
    localparam int CNT_W   = $clog2(MAX_TASKS + 1);
    localparam int NW      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int SW      = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int WW      = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;
    localparam int ENTRY_W = $bits(opts_entry_t);
    localparam int WORD_W  = ENTRY_W + TIME_BITS;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_UPD,
        ST_RES
    } state_t;

    function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] t);
        sat_inc = (t == TIME_MAX) ? TIME_MAX : t + 1'b1;
    endfunction

    state_t                 state_reg;
    logic [TIME_BITS-1:0]   tick_reg;
    logic [MAX_TASKS-1:0]   done_reg;
    opts_in_t               item_reg;
    logic [NW-1:0]          n_reg;
    logic [NW-1:0]          rd_cnt_reg;
    logic                   pend_reg;
    logic [IDX_W-1:0]       pend_idx_reg;
    logic                   found_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    logic [ORDER_W-1:0]     best_ord_reg;
    opts_entry_t            best_entry_reg;
    logic [TIME_BITS-1:0]   best_fr_reg;
    logic [1:0]             und_cnt_reg;
    logic                   fin_reg;
    logic [TIME_BITS-1:0]   fr_reg;
    logic [WW-1:0]          ta_reg;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [WORD_W-1:0]      ram_wdata;
    logic [WORD_W-1:0]      ram_rdata;
    opts_entry_t            q_entry;
    logic [TIME_BITS-1:0]   q_fr;

    logic [NW-1:0]          n_lim;
    logic [SW-1:0]          slot_w;
    logic                   slot_ok;
    logic                   cand;
    logic                   scan_end;

    opts_entry_t            load_entry;
    opts_entry_t            upd_entry;
    logic                   upd_fin;
    logic [TIME_BITS-1:0]   upd_fr;
    logic [WW-1:0]          upd_ta;

    logic [WW-1:0]          t_w;
    logic [WW-1:0]          arr_w;
    logic [WW-1:0]          fr_w;
    logic [WW-1:0]          resp_w;
    logic [WW-1:0]          wait_w;
    logic [SW-1:0]          chosen_w;

    opts_task_ram #(
        .DATA_W (WORD_W),
        .DEPTH  (MAX_TASKS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (rd_cnt_reg[IDX_W-1:0]),
        .rd_data (ram_rdata)
    );

    assign q_entry = ram_rdata[ENTRY_W-1:0];
    assign q_fr    = ram_rdata[WORD_W-1:ENTRY_W];

    assign n_lim   = (NW'(num_tasks) > NW'(MAX_TASKS)) ? NW'(MAX_TASKS) : NW'(num_tasks);
    assign slot_w  = SW'(item_reg.slot);
    assign slot_ok = (32'(item_reg.slot) < 32'(MAX_TASKS));

    assign cand = pend_reg && (item_reg.op == OP_TICK) && !done_reg[pend_idx_reg]
                  && (WW'(q_entry.arrival) <= WW'(tick_reg));
    assign scan_end = (rd_cnt_reg == n_reg) && !pend_reg;

    always_comb begin
        load_entry           = '0;
        load_entry.arrival   = item_reg.arrival;
        load_entry.burst     = item_reg.burst;
        load_entry.order     = item_reg.order;
        load_entry.remaining = item_reg.burst;

        upd_fin   = (best_entry_reg.remaining <= FIELD_W'(1));
        upd_fr    = (best_entry_reg.remaining == best_entry_reg.burst) ? tick_reg : best_fr_reg;
        upd_ta    = WW'(sat_inc(tick_reg)) - WW'(best_entry_reg.arrival);
        upd_entry = best_entry_reg;
        upd_entry.remaining = upd_fin ? '0 : best_entry_reg.remaining - 1'b1;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = best_idx_reg;
        ram_wdata = {upd_fr, upd_entry};
        unique case (state_reg)
            ST_LOAD: begin
                ram_we    = slot_ok;
                ram_waddr = slot_w[IDX_W-1:0];
                ram_wdata = {{TIME_BITS{1'b0}}, load_entry};
            end
            ST_UPD: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            tick_reg   <= '0;
            done_reg   <= '1;
            pend_reg   <= 1'b0;
            rd_cnt_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        item_reg    <= in_data;
                        n_reg       <= n_lim;
                        rd_cnt_reg  <= '0;
                        pend_reg    <= 1'b0;
                        found_reg   <= 1'b0;
                        und_cnt_reg <= '0;
                        fin_reg     <= 1'b0;
                        state_reg   <= (in_data.op == OP_TICK) ? ST_SCAN : ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (slot_ok) begin
                        done_reg[slot_w[IDX_W-1:0]] <= 1'b0;
                    end
                    state_reg <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (rd_cnt_reg != n_reg) begin
                        pend_reg     <= 1'b1;
                        pend_idx_reg <= rd_cnt_reg[IDX_W-1:0];
                        rd_cnt_reg   <= rd_cnt_reg + 1'b1;
                    end else begin
                        pend_reg <= 1'b0;
                    end
                    if (pend_reg && !done_reg[pend_idx_reg] && und_cnt_reg != 2'd2) begin
                        und_cnt_reg <= und_cnt_reg + 1'b1;
                    end
                    if (cand && (!found_reg || q_entry.order < best_ord_reg)) begin
                        found_reg      <= 1'b1;
                        best_idx_reg   <= pend_idx_reg;
                        best_ord_reg   <= q_entry.order;
                        best_entry_reg <= q_entry;
                        best_fr_reg    <= q_fr;
                    end
                    if (scan_end) begin
                        state_reg <= (item_reg.op == OP_TICK && found_reg) ? ST_UPD : ST_RES;
                    end
                end
                ST_UPD: begin
                    fin_reg <= upd_fin;
                    fr_reg  <= upd_fr;
                    ta_reg  <= upd_ta;
                    if (upd_fin) begin
                        done_reg[best_idx_reg] <= 1'b1;
                    end
                    state_reg <= ST_RES;
                end
                ST_RES: begin
                    if (res_ready) begin
                        tick_reg  <= (item_reg.op == OP_TICK) ? sat_inc(tick_reg) : '0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RES);

    always_comb begin
        t_w      = WW'(tick_reg);
        arr_w    = WW'(best_entry_reg.arrival);
        fr_w     = WW'(fr_reg);
        resp_w   = (fr_w >= arr_w) ? fr_w - arr_w : '0;
        wait_w   = (ta_reg >= WW'(best_entry_reg.burst)) ? ta_reg - WW'(best_entry_reg.burst) : '0;
        chosen_w = SW'(best_idx_reg);

        res_data          = '0;
        res_data.all_done = (und_cnt_reg == 2'd0) || (fin_reg && und_cnt_reg == 2'd1);
        if (item_reg.op == OP_LOAD) begin
            res_data.idle = 1'b1;
        end else begin
            res_data.time_now = t_w[FIELD_W-1:0];
            if (!found_reg) begin
                res_data.idle = 1'b1;
            end else begin
                res_data.chosen   = chosen_w[SLOT_W-1:0];
                res_data.finished = fin_reg;
                if (fin_reg) begin
                    res_data.response   = resp_w[FIELD_W-1:0];
                    res_data.waiting    = wait_w[FIELD_W-1:0];
                    res_data.turnaround = ta_reg[FIELD_W-1:0];
                end
            end
        end
    end

    // The chosen entry is still pending when it is written back.
    a_upd_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD) |-> (found_reg && !done_reg[best_idx_reg]))
        else $error("update of an entry that is not pending");

    // A read in flight only exists while the scan runs.
    a_pend_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (state_reg == ST_SCAN))
        else $error("table read outstanding outside the scan");

    // The scan never walks past the entries in use.
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (rd_cnt_reg <= n_reg))
        else $error("scan counter beyond entries in use");

    // A tick advances time by one, saturating; a load clears it.
    a_tick_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready && item_reg.op == OP_TICK)
        |=> (tick_reg == sat_inc($past(tick_reg))))
        else $error("time counter did not advance by one");

endmodule

>>> rtl/order_priority_tick_scheduler_top.sv
// Top level of the order priority tick scheduler: handshake ports, the
// num_tasks register and the result register. Uses opts_pkg, opts_sched_core.
//
//  Channel   Ports                         Direction  Transaction
//  -------   ----------------------------  ---------  ---------------------------
//  input     s_valid, s_ready, s_data      in         one load or one tick item
//  result    m_valid, m_ready, m_data      out        one result per input item
//  config    cfg_valid, cfg_ready, cfg_data in        write of num_tasks
//
// An item goes from acceptance through a scan of the n = min(num_tasks,
// MAX_TASKS) entries in use, which reads one task table entry per cycle
// through the single read port of the table memory, and then to its result.
// Reset is synchronous and active low; it marks every entry done, clears the
// time counter and sets num_tasks to one. The table contents are not cleared.
// A stalled result sits in the output register while the next item is taken.
`timescale 1ns / 1ps

module order_priority_tick_scheduler_top
    import opts_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             s_valid,
    output logic             s_ready,
    input  opts_in_t         s_data,

    output logic             m_valid,
    input  logic             m_ready,
    output opts_out_t        m_data,

    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [CFG_W-1:0] num_tasks_reg;
    logic             m_valid_reg;
    opts_out_t        m_data_reg;

    logic             res_valid;
    logic             res_ready;
    opts_out_t        res_data;

    // The register write is always taken; software must write it only while the
    // block has no transaction in flight, which the block itself does not enforce.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_tasks_reg <= CFG_W'(1);
        end else if (cfg_valid) begin
            num_tasks_reg <= cfg_data;
        end
    end

    opts_sched_core #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .num_tasks (num_tasks_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // The output register takes a new result whenever it is empty or its
    // current result is being taken in the same cycle.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (res_ready) begin
                m_valid_reg <= res_valid;
            end
            if (res_ready && res_valid) begin
                m_data_reg <= res_data;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> test/opts_sched_checker.sv
// Result checker for the order priority tick scheduler: follows the input, result
// and num_tasks channels, predicts every result and compares it field by field.
// Depends on opts_pkg.
`timescale 1ns / 1ps

module opts_sched_checker
    import opts_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  opts_in_t         s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  opts_out_t        m_data,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    output int               fail_count,
    output int               pending_count
);

    localparam int TABLE_DEPTH = 16;
    localparam logic [FIELD_W-1:0] TICK_LIMIT = '1;
    localparam int PRINT_LIMIT = 100;

    // Shadow copy of the task table and the scheduler clock.
    logic [FIELD_W-1:0]     arrival_at [TABLE_DEPTH];
    logic [FIELD_W-1:0]     burst_of   [TABLE_DEPTH];
    logic [ORDER_W-1:0]     rank_of    [TABLE_DEPTH];
    logic [FIELD_W-1:0]     left_of    [TABLE_DEPTH];
    logic [FIELD_W-1:0]     started_at [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] retired;
    logic [FIELD_W-1:0]     clock_now;
    logic [CFG_W-1:0]       task_count;

    opts_out_t due_outcomes [$];
    opts_out_t oldest;

    function automatic int slots_in_use();
        return (task_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(task_count);
    endfunction

    function automatic logic every_task_retired();
        logic all_set;
        int   i;
        all_set = 1'b1;
        for (i = 0; i < slots_in_use(); i++) begin
            if (!retired[i]) all_set = 1'b0;
        end
        return all_set;
    endfunction

    // The clock stops at its top value instead of wrapping.
    function automatic logic [FIELD_W-1:0] bump(logic [FIELD_W-1:0] t);
        return (t == TICK_LIMIT) ? t : t + 1'b1;
    endfunction

    function automatic opts_out_t schedule_item(opts_in_t item);
        opts_out_t          res;
        logic               found;
        int                 pick;
        int                 i;
        logic [FIELD_W-1:0] done_at;
        logic [FIELD_W-1:0] span;
        res = '0;
        if (item.op == OP_LOAD) begin
            arrival_at[item.slot] = item.arrival;
            burst_of[item.slot]   = item.burst;
            rank_of[item.slot]    = item.order;
            left_of[item.slot]    = item.burst;
            started_at[item.slot] = '0;
            retired[item.slot]    = 1'b0;
            clock_now = '0;
            res.idle = 1'b1;
        end else begin
            found = 1'b0;
            pick  = 0;
            // Strict less-than keeps the lowest index among equal orders.
            for (i = 0; i < slots_in_use(); i++) begin
                if (!retired[i] && arrival_at[i] <= clock_now &&
                    (!found || rank_of[i] < rank_of[pick])) begin
                    found = 1'b1;
                    pick  = i;
                end
            end
            res.time_now = clock_now;
            if (!found) begin
                res.idle = 1'b1;
            end else begin
                res.chosen = SLOT_W'(pick);
                if (left_of[pick] == burst_of[pick]) started_at[pick] = clock_now;
                // A zero burst finishes on its first run just like a burst of one.
                if (left_of[pick] <= 1) begin
                    done_at = bump(clock_now);
                    span    = done_at - arrival_at[pick];
                    left_of[pick] = '0;
                    retired[pick] = 1'b1;
                    res.finished   = 1'b1;
                    res.response   = (started_at[pick] >= arrival_at[pick]) ?
                                     started_at[pick] - arrival_at[pick] : '0;
                    res.waiting    = (span >= burst_of[pick]) ? span - burst_of[pick] : '0;
                    res.turnaround = span;
                end else begin
                    left_of[pick] = left_of[pick] - 1'b1;
                end
            end
            clock_now = bump(clock_now);
        end
        res.all_done = every_task_retired();
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        fail_count++;
        if (fail_count <= PRINT_LIMIT) $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(string name, logic [FIELD_W-1:0] got,
                                 logic [FIELD_W-1:0] want);
        if (got !== want) report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                arrival_at[i] = '0;
                burst_of[i]   = '0;
                rank_of[i]    = '0;
                left_of[i]    = '0;
                started_at[i] = '0;
            end
            retired    = '1;
            clock_now  = '0;
            task_count = CFG_W'(1);
            due_outcomes.delete();
        end else begin
            if (cfg_valid && cfg_ready) task_count = cfg_data;
            // Results are taken before new inputs so that a result can never be
            // matched against an item accepted on the same edge.
            if (m_valid && m_ready) begin
                if (due_outcomes.size() == 0) begin
                    report_mismatch("result transaction with no item outstanding");
                end else begin
                    oldest = due_outcomes.pop_front();
                    compare_field("time_now", m_data.time_now, oldest.time_now);
                    compare_field("idle", FIELD_W'(m_data.idle), FIELD_W'(oldest.idle));
                    compare_field("chosen", FIELD_W'(m_data.chosen), FIELD_W'(oldest.chosen));
                    compare_field("finished", FIELD_W'(m_data.finished),
                                  FIELD_W'(oldest.finished));
                    compare_field("response", m_data.response, oldest.response);
                    compare_field("waiting", m_data.waiting, oldest.waiting);
                    compare_field("turnaround", m_data.turnaround, oldest.turnaround);
                    compare_field("all_done", FIELD_W'(m_data.all_done),
                                  FIELD_W'(oldest.all_done));
                end
            end
            if (s_valid && s_ready) due_outcomes.push_back(schedule_item(s_data));
        end
        pending_count <= due_outcomes.size();
    end

endmodule

>>> test/tb_order_priority_tick_scheduler_top.sv
// Testbench top for the order priority tick scheduler: clock, reset, stimulus
// and the final verdict. Depends on opts_pkg, opts_sched_checker and the RTL top.
`timescale 1ns / 1ps

module tb_order_priority_tick_scheduler_top;
    import opts_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    localparam int TABLE_DEPTH  = 16;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    opts_in_t         s_data;
    logic             m_valid;
    logic             m_ready;
    opts_out_t        m_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    int fail_count;
    int pending_count;

    // When calm is set, neither the sender nor the receiver inserts idle cycles.
    bit calm;
    int items_sent;
    // Number of table entries the scheduler currently looks at, as the DUT sees it.
    int task_count;

    order_priority_tick_scheduler_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    opts_sched_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Hard stop. The slowest legitimate run, with every item taking the longest
    // gaps on both sides, stays well below a tenth of this.
    initial begin
        #(50_000_000);
        $display("[order_priority_tick_scheduler_top] ERROR");
        $finish;
    end

    // Result side: before each result the receiver holds off a random number of
    // cycles, then keeps ready high until a result transaction completes.
    initial begin
        int gap;
        m_ready = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 15);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Sends one item. Valid is left high after acceptance; the next call either
    // replaces the payload at once or drops valid for its gap, so valid only ever
    // gets one assignment per edge. Whoever stops sending must drop valid itself.
    task automatic send_item(input opts_in_t item);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic load_task(input int slot, input int arrival, input int burst, input int order);
        opts_in_t item;
        item.op      = OP_LOAD;
        item.slot    = SLOT_W'(slot);
        item.arrival = FIELD_W'(arrival);
        item.burst   = FIELD_W'(burst);
        item.order   = ORDER_W'(order);
        send_item(item);
    endtask

    task automatic tick();
        opts_in_t item;
        item      = '0;
        item.op   = OP_TICK;
        // The payload fields of a tick are ignored, so its slot field carries noise.
        item.slot = SLOT_W'($urandom);
        send_item(item);
    endtask

    // Stops the sender and waits until every outstanding result has been taken.
    task automatic pause_sender();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
    endtask

    // Must only be called with the sender paused and nothing outstanding.
    task automatic write_task_count(input int count);
        cfg_valid <= 1'b1;
        cfg_data  <= CFG_W'(count);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        task_count = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
    endtask

    // Half of the orders come from a tiny range so that ties are common.
    function automatic int pick_order();
        return ($urandom_range(0, 1) != 0) ? $urandom_range(0, 127) : $urandom_range(0, 3);
    endfunction

    function automatic int pick_task_count();
        case ($urandom_range(0, 6))
            0:       return 0;
            1:       return 1;
            2:       return 16;
            3:       return 31;
            4:       return $urandom_range(17, 30);
            default: return $urandom_range(2, 15);
        endcase
    endfunction

    // A well-formed schedule: every entry in use is reloaded with short work and
    // early arrivals, then enough ticks follow to finish them all, plus a few idle
    // ones. Now and then a load lands in the middle of the ticks, which restarts
    // the clock under the running tasks.
    task automatic well_formed_batch();
        int k;
        int rot;
        int arrival;
        int work;
        int latest;
        int total;
        int ticks;
        int cut;
        latest = 0;
        total  = 0;
        if (task_count == 0) begin
            load_task($urandom_range(0, 15), $urandom_range(0, 3), $urandom_range(0, 4),
                      pick_order());
            repeat (3) tick();
        end else begin
            rot = $urandom_range(0, TABLE_DEPTH - 1);
            for (k = 0; k < task_count; k++) begin
                arrival = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                work    = $urandom_range(0, 6);
                load_task((k + rot) % task_count, arrival, work, pick_order());
                total += (work == 0) ? 1 : work;
                if (arrival > latest) latest = arrival;
            end
            ticks = total + latest + $urandom_range(0, 3);
            cut   = ($urandom_range(0, 4) == 0) ? $urandom_range(1, ticks) : -1;
            for (k = 0; k < ticks; k++) begin
                if (k == cut) begin
                    load_task($urandom_range(0, task_count - 1), $urandom_range(0, 8),
                              $urandom_range(0, 4), pick_order());
                end
                tick();
            end
        end
    endtask

    // Unstructured traffic with full-width field values.
    task automatic noise_batch();
        repeat (8) begin
            if ($urandom_range(0, 1) != 0) begin
                tick();
            end else begin
                load_task($urandom_range(0, 15), $urandom, $urandom, $urandom_range(0, 127));
            end
        end
    endtask

    initial begin
        int batch;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        calm       = 1'b0;
        items_sent = 0;
        task_count = 1;
        batch      = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Nothing has been loaded yet, so the single entry in use counts as done.
        tick();

        // Full table. Slot 15 has zero work, slot 3 ties with it on order zero
        // and arrives one tick later, slot 0 has the largest order, and slot 7
        // has maximal arrival and burst so it never becomes ready.
        pause_sender();
        write_task_count(16);
        load_task(0, 0, 2, 127);
        load_task(15, 0, 0, 0);
        load_task(3, 1, 1, 0);
        load_task(7, 65535, 65535, 99);
        repeat (5) tick();

        // Preemption: slot 9 starts alone and is pushed aside by slot 5 when it
        // arrives with a better order, then resumes.
        load_task(9, 0, 4, 60);
        load_task(5, 2, 1, 10);
        repeat (5) tick();

        // No entries in use: everything reads as done even with a fresh load.
        pause_sender();
        write_task_count(0);
        tick();
        load_task(2, 5, 5, 5);

        // Register value above the table size acts as the full table.
        pause_sender();
        write_task_count(31);
        tick();

        // Random part. The register changes every few batches, which also makes
        // the sender wait for all outstanding results at those points.
        while (items_sent < 20 + RANDOM_ITEMS) begin
            if (batch % 5 == 0) begin
                pause_sender();
                write_task_count(pick_task_count());
            end
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) < 7) begin
                well_formed_batch();
            end else begin
                noise_batch();
            end
            batch++;
        end

        pause_sender();
        // A few cycles more so that any stray result would still be caught.
        repeat (40) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[order_priority_tick_scheduler_top] OK");
        end else begin
            $display("[order_priority_tick_scheduler_top] ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/opts_pkg.sv
rtl/opts_task_ram.sv
rtl/opts_sched_core.sv
rtl/order_priority_tick_scheduler_top.sv
test/opts_sched_checker.sv
test/tb_order_priority_tick_scheduler_top.sv
